// ----- src/nfwe_pkg.sv -----
package nfwe_pkg;

	localparam int SEQ_W  = 32;
	localparam int WIN_W  = 9;
	localparam int DUP_W  = 8;
	localparam int THR_W  = 4;
	localparam int FLOW_W = 10;
	localparam int CMD_W  = 2;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	// upper bound on any window after an ack, on top of the window_limit register
	localparam int MAX_WINDOW = 256;

	localparam logic [WIN_W-1:0] RST_INIT_WINDOW = 9'd10;
	localparam logic [WIN_W-1:0] RST_INIT_SS     = 9'd60;
	localparam logic [THR_W-1:0] RST_DUP_THR     = 4'd3;
	localparam logic [WIN_W-1:0] RST_WIN_LIMIT   = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACK     = 2'd0,
		CMD_TIMEOUT = 2'd1,
		CMD_SEND    = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		REG_INIT_WINDOW = 2'd0,
		REG_INIT_SS     = 2'd1,
		REG_DUP_THR     = 2'd2,
		REG_WIN_LIMIT   = 2'd3
	} reg_e_t;

	// one flow context as held in the context memory
	typedef struct packed {
		logic [SEQ_W-1:0] ws;
		logic [SEQ_W-1:0] nxt_seq;
		logic [WIN_W-1:0] wsize;
		logic [WIN_W-1:0] ss;
		logic [DUP_W-1:0] dup;
		logic [WIN_W-1:0] inc;
		logic [SEQ_W-1:0] rec;
		logic [SEQ_W-1:0] prev;
		logic             in_rec;
		logic             in_to;
		logic             used;
	} ctx_t;

endpackage

// ----- src/newreno_flow_window_engine_core.sv -----
// The context read happens at the accepting edge; the result reaches the output register when the
// update stage moves on. Throughput: one word per cycle when not stalled; the context memory does
// one read and one write-back per cycle, with the written context forwarded when the next word
// addresses the same flow. Reset: control registers clear and configuration registers load their
// reset values at once; then a sweep clears the context memory, one flow per cycle, and in_stall
// stays high until it ends.
module newreno_flow_window_engine_core #(
	parameter int FLOWS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nfwe_pkg::ADDR_W-1:0]   paddr,
	input  logic [nfwe_pkg::DATA_W-1:0]   pwdata,
	output logic [nfwe_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nfwe_pkg::CMD_W-1:0]    command,
	input  logic [nfwe_pkg::FLOW_W-1:0]   flow,
	input  logic [nfwe_pkg::SEQ_W-1:0]    cum_ack,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nfwe_pkg::FLOW_W-1:0]   flow_out,
	output logic                          send_valid,
	output logic [nfwe_pkg::SEQ_W-1:0]    send_seq,
	output logic [nfwe_pkg::WIN_W-1:0]    window,
	output logic                          retransmit_valid,
	output logic [nfwe_pkg::SEQ_W-1:0]    retransmit_seq,
	output logic                          restart_timer,
	output logic                          recovering,
	output logic                          window_full
);
	import nfwe_pkg::*;

	localparam int IDXW = $clog2(FLOWS);
	localparam int EXTW = (IDXW > FLOW_W) ? IDXW : FLOW_W;

	// configuration registers
	logic [WIN_W-1:0] init_window_q;
	logic [WIN_W-1:0] init_ss_q;
	logic [THR_W-1:0] dup_thr_q;
	logic [WIN_W-1:0] win_limit_q;
	logic             cfg_wr;

	// context memory and its clearing sweep
	ctx_t             ctx_mem [FLOWS];
	logic             clearing_q;
	logic [IDXW-1:0]  clr_q;
	logic             mem_we;
	logic [IDXW-1:0]  mem_wa;
	ctx_t             mem_wd;

	// input side
	logic             accept;
	logic [EXTW-1:0]  flow_ext;
	logic [IDXW-1:0]  in_idx;
	logic             in_range;

	// update stage
	logic             valid_s1;
	logic             fwd_s1;
	cmd_e_t           cmd_s1;
	logic [FLOW_W-1:0] flow_s1;
	logic [SEQ_W-1:0] cack_s1;
	logic [IDXW-1:0]  idx_s1;
	logic             inr_s1;
	ctx_t             rd_s1;
	ctx_t             fwd_ent_s1;
	logic             s1_adv;

	// update results
	ctx_t             nx;
	logic             r_send;
	logic [SEQ_W-1:0] r_send_seq;
	logic             r_rtx;
	logic [SEQ_W-1:0] r_rtx_seq;
	logic             r_restart;

	// output register
	logic             out_valid_q;
	logic [FLOW_W-1:0] flow_out_q;
	logic             send_valid_q;
	logic [SEQ_W-1:0] send_seq_q;
	logic [WIN_W-1:0] window_q;
	logic             rtx_valid_q;
	logic [SEQ_W-1:0] rtx_seq_q;
	logic             restart_q;
	logic             recovering_q;
	logic             full_en_q;
	logic [SEQ_W-1:0] ws_q;
	logic [SEQ_W-1:0] nxt_q;
	logic [SEQ_W-1:0] win_end;

	//------------------------------------------------------------------
	// Configuration: pready is always high, reads decode paddr[3:2].
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_window_q <= RST_INIT_WINDOW;
			init_ss_q     <= RST_INIT_SS;
			dup_thr_q     <= RST_DUP_THR;
			win_limit_q   <= RST_WIN_LIMIT;
		end else if (cfg_wr) begin
			case (reg_e_t'(paddr[3:2]))
				REG_INIT_WINDOW: init_window_q <= pwdata[WIN_W-1:0];
				REG_INIT_SS:     init_ss_q     <= pwdata[WIN_W-1:0];
				REG_DUP_THR:     dup_thr_q     <= pwdata[THR_W-1:0];
				REG_WIN_LIMIT:   win_limit_q   <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_e_t'(paddr[3:2]))
			REG_INIT_WINDOW: prdata = DATA_W'(init_window_q);
			REG_INIT_SS:     prdata = DATA_W'(init_ss_q);
			REG_DUP_THR:     prdata = DATA_W'(dup_thr_q);
			REG_WIN_LIMIT:   prdata = DATA_W'(win_limit_q);
			default:         prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshake. The update stage moves on when the output register is
	// empty or being emptied; a new word enters only behind it.
	//------------------------------------------------------------------
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;

	assign flow_ext = EXTW'(flow);
	assign in_idx   = flow_ext[IDXW-1:0];
	assign in_range = (32'(flow) < 32'(FLOWS));

	//------------------------------------------------------------------
	// Clearing sweep after reset: zero every context, used bit included.
	// Flows pick up their window and threshold from the registers on first use.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == IDXW'(FLOWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// one write port: the sweep or the write-back of the update stage
	assign mem_we = clearing_q || (s1_adv && inr_s1);
	assign mem_wa = clearing_q ? clr_q : idx_s1;
	assign mem_wd = clearing_q ? '0 : nx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ctx_mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			rd_s1 <= ctx_mem[in_idx];
		end
	end

	//------------------------------------------------------------------
	// Update stage registers. Forward the context written at the same
	// edge when the new word addresses the same flow: the memory read
	// at that edge still returns the old contents.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= s1_adv && inr_s1 && (idx_s1 == in_idx);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_e_t'(command);
			flow_s1    <= flow;
			cack_s1    <= cum_ack;
			idx_s1     <= in_idx;
			inr_s1     <= in_range;
			fwd_ent_s1 <= nx;
		end
	end

	//------------------------------------------------------------------
	// Context update for one command.
	//------------------------------------------------------------------
	always_comb begin
		ctx_t             ent;
		logic [WIN_W-1:0] lim;
		logic             is_new;
		logic             is_dup;
		logic             above_rec;
		logic             fast;
		logic             full;
		logic             partial;
		logic             in_rec_n;
		logic [DUP_W-1:0] dup_n;
		logic [SEQ_W-1:0] new_start;
		logic [SEQ_W-1:0] w_in;
		logic [SEQ_W-1:0] w_out;

		ent = fwd_s1 ? fwd_ent_s1 : rd_s1;
		// first touch of a flow: load window and threshold from the registers
		if (!ent.used) begin
			ent.wsize = init_window_q;
			ent.ss    = init_ss_q;
		end

		lim = (32'(win_limit_q) > 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_limit_q;

		is_new    = cack_s1 > ent.ws;
		is_dup    = cack_s1 == ent.ws;
		above_rec = cack_s1 > ent.rec;
		new_start = is_new ? cack_s1 : ent.ws;
		w_in      = SEQ_W'(ent.wsize);

		if (is_new) begin
			dup_n = '0;
		end else if (is_dup && ent.dup != {DUP_W{1'b1}}) begin
			dup_n = ent.dup + 1'b1;
		end else begin
			dup_n = ent.dup;
		end

		fast = (dup_n == DUP_W'(dup_thr_q)) &&
		       (above_rec || (ent.wsize > WIN_W'(1) && (cack_s1 - ent.prev) <= SEQ_W'(4)));
		full     = is_new && above_rec;
		partial  = is_new && !above_rec;
		in_rec_n = (ent.in_rec && !above_rec) || fast;

		// window before clamping, 32-bit wrap
		if (ent.in_rec && !ent.in_to) begin
			if (full) begin
				w_out = SEQ_W'(ent.ss);
			end else if (partial) begin
				w_out = w_in + (cack_s1 - ent.ws) + 1'b1;
			end else if (is_dup) begin
				w_out = w_in + 1'b1;
			end else begin
				w_out = w_in;
			end
		end else if (is_new) begin
			if (ent.wsize < ent.ss || ent.inc == ent.wsize) begin
				w_out = w_in - SEQ_W'(ent.dup) + 1'b1;
			end else begin
				w_out = w_in - SEQ_W'(ent.dup);
			end
		end else if (is_dup) begin
			w_out = w_in + 1'b1;
		end else begin
			w_out = w_in;
		end

		nx         = ent;
		nx.used    = 1'b1;
		r_send     = 1'b0;
		r_send_seq = '0;
		r_rtx      = 1'b0;
		r_rtx_seq  = '0;
		r_restart  = 1'b0;

		case (cmd_s1)
			CMD_ACK: begin
				nx.ws     = new_start;
				nx.dup    = dup_n;
				nx.wsize  = (w_out > SEQ_W'(lim)) ? lim : w_out[WIN_W-1:0];
				nx.in_rec = in_rec_n;
				if (in_rec_n && !ent.in_to) begin
					nx.inc = '0;
				end else if (is_new && !(ent.wsize < ent.ss)) begin
					nx.inc = (ent.inc == ent.wsize) ? '0 : ent.inc + 1'b1;
				end
				nx.in_to = ent.in_to && !full;
				if (is_new) begin
					nx.prev = ent.ws;
				end
				if (fast) begin
					nx.rec = ent.nxt_seq - 1'b1;
					nx.ss  = ent.wsize >> 1;
				end
				r_rtx     = fast || partial;
				r_rtx_seq = (fast || partial) ? new_start : '0;
				r_restart = !in_rec_n;
			end
			CMD_TIMEOUT: begin
				nx.wsize  = WIN_W'(1);
				nx.dup    = '0;
				nx.ss     = (ent.ss > WIN_W'(2)) ? WIN_W'(2) : ent.ss;
				nx.inc    = '0;
				nx.in_to  = 1'b1;
				nx.rec    = ent.nxt_seq - 1'b1;
				r_rtx     = 1'b1;
				r_rtx_seq = ent.ws;
			end
			CMD_SEND: begin
				if (ent.nxt_seq < ent.ws + SEQ_W'(ent.wsize)) begin
					r_send     = 1'b1;
					r_send_seq = ent.nxt_seq;
					nx.nxt_seq = ent.nxt_seq + 1'b1;
				end
			end
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// Output register. Drop every field but the flow for an out-of-range flow.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			flow_out_q   <= flow_s1;
			send_valid_q <= inr_s1 && r_send;
			send_seq_q   <= inr_s1 ? r_send_seq : '0;
			window_q     <= inr_s1 ? nx.wsize : '0;
			rtx_valid_q  <= inr_s1 && r_rtx;
			rtx_seq_q    <= inr_s1 ? r_rtx_seq : '0;
			restart_q    <= inr_s1 && r_restart;
			recovering_q <= inr_s1 && nx.in_rec;
			full_en_q    <= inr_s1;
			ws_q         <= nx.ws;
			nxt_q        <= nx.nxt_seq;
		end
	end

	// window end wraps at 32 bits
	assign win_end = ws_q + SEQ_W'(window_q);

	assign out_valid        = out_valid_q;
	assign flow_out         = flow_out_q;
	assign send_valid       = send_valid_q;
	assign send_seq         = send_seq_q;
	assign window           = window_q;
	assign retransmit_valid = rtx_valid_q;
	assign retransmit_seq   = rtx_seq_q;
	assign restart_timer    = restart_q;
	assign recovering       = recovering_q;
	assign window_full      = full_en_q && (nxt_q >= win_end);

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1 && !fwd_s1)
		else $error("update stage busy during context clearing");

	a_fwd_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarding flag set with empty update stage");

	a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(idx_s1) && $stable(cack_s1))
		else $error("blocked update stage lost its word");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach update stage");

	a_marks_zero_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid && !retransmit_valid |-> send_seq == '0 && retransmit_seq == '0)
		else $error("sequence reported without its mark");

endmodule

// ----- test/tb_newreno_flow_window_engine_core.sv -----
`timescale 1ns / 100ps

module tb_newreno_flow_window_engine_core;
	import nfwe_pkg::*;

	// command code outside the defined set; the block must report, changing nothing but the first-use setup
	localparam logic [CMD_W-1:0] CMD_OTHER = 2'd3;
	localparam int NUM_FLOWS = 1024;
	// longest stretch with no word moving: reset sweep of all flows plus the long
	// receiver hold, taken a few times over
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 300;

	// per-flow sender context as the predictor keeps it
	typedef struct {
		logic [SEQ_W-1:0] wstart;
		logic [SEQ_W-1:0] nxt;
		logic [WIN_W-1:0] wsize;
		logic [WIN_W-1:0] ssthr;
		logic [DUP_W-1:0] dups;
		logic [WIN_W-1:0] incr;
		logic [SEQ_W-1:0] recov;
		logic [SEQ_W-1:0] prev_ack;
		logic             in_rec;
		logic             in_to;
		logic             touched;
	} flow_ctx_t;

	typedef struct {
		logic [WIN_W-1:0] init_win;
		logic [WIN_W-1:0] init_ss;
		logic [THR_W-1:0] dup_thr;
		logic [WIN_W-1:0] win_lim;
	} tuning_t;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [FLOW_W-1:0] fl;
		logic [SEQ_W-1:0]  cack;
	} cmd_word_t;

	typedef struct {
		logic [FLOW_W-1:0] flow_id;
		logic              send_v;
		logic [SEQ_W-1:0]  send_s;
		logic [WIN_W-1:0]  win;
		logic              rtx_v;
		logic [SEQ_W-1:0]  rtx_s;
		logic              restart;
		logic              recov;
		logic              full;
	} reno_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = '0;
	logic [FLOW_W-1:0]   flow = '0;
	logic [SEQ_W-1:0]    cum_ack = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FLOW_W-1:0]   flow_out;
	logic                send_valid;
	logic [SEQ_W-1:0]    send_seq;
	logic [WIN_W-1:0]    window;
	logic                retransmit_valid;
	logic [SEQ_W-1:0]    retransmit_seq;
	logic                restart_timer;
	logic                recovering;
	logic                window_full;

	newreno_flow_window_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .flow(flow), .cum_ack(cum_ack),
		.out_valid(out_valid), .out_stall(out_stall),
		.flow_out(flow_out), .send_valid(send_valid), .send_seq(send_seq),
		.window(window), .retransmit_valid(retransmit_valid),
		.retransmit_seq(retransmit_seq), .restart_timer(restart_timer),
		.recovering(recovering), .window_full(window_full)
	);

	always #6 clk = ~clk;

	// two context copies: one advanced as words are planned (to aim acks at live
	// sequence ranges), one advanced as words are accepted (to predict results)
	flow_ctx_t    ctx_plan [NUM_FLOWS];
	flow_ctx_t    ctx_model [NUM_FLOWS];
	flow_ctx_t    ctx_now;
	tuning_t      tuning;
	cmd_word_t    cmd_backlog [$];
	cmd_word_t    next_word;
	reno_result_t due_results [$];
	reno_result_t want;

	int  failures = 0;
	int  words_queued = 0;
	int  results_seen = 0;
	int  quiet_cycles = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_req = 0;
	int  hold_left = 0;
	int  n_ack = 0, n_timeout = 0, n_send = 0, n_other = 0;
	int  n_rtx = 0, n_issued = 0, n_recov = 0;
	bit  word_taken = 1'b0;
	bit  result_taken = 1'b0;
	bit  offering = 1'b0;
	bit  busy = 1'b0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;

	// Apply one command to one flow context and return the result word it yields.
	// Ack window math runs in 32 bits with wrap, then clamps to the effective limit.
	function automatic reno_result_t newreno_step(inout flow_ctx_t c, input tuning_t k,
			input logic [CMD_W-1:0] op, input logic [FLOW_W-1:0] fl,
			input logic [SEQ_W-1:0] cack);
		reno_result_t r;
		logic [31:0]  old_start, w_in, ss, old_dup, dup, rec, w_out, lim, wend;
		logic         was_rec, was_to, is_new, is_dup, fast, full, partial, rtx;
		r = '{default: '0};
		r.flow_id = fl;
		rtx = 1'b0;
		// a flow picks up its initial window and threshold on first use
		if (!c.touched) begin
			c.touched = 1'b1;
			c.wsize = k.init_win;
			c.ssthr = k.init_ss;
		end
		case (op)
			CMD_ACK: begin
				old_start = c.wstart;
				w_in = 32'(c.wsize);
				ss = 32'(c.ssthr);
				old_dup = 32'(c.dups);
				rec = c.recov;
				was_rec = c.in_rec;
				was_to = c.in_to;
				is_new = cack > old_start;
				is_dup = cack == old_start;
				lim = (32'(k.win_lim) > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : 32'(k.win_lim);
				if (is_new)
					c.wstart = cack;
				dup = old_dup;
				if (is_new)
					dup = 0;
				else if (is_dup && dup < 255)
					dup = dup + 1;
				c.dups = dup[7:0];
				// a zero threshold matches the cleared count of a fresh ack
				fast = (dup == 32'(k.dup_thr)) &&
					((cack > rec) || (w_in > 1 && (cack - c.prev_ack) <= 32'd4));
				full = is_new && cack > rec;
				partial = is_new && cack <= rec;
				rtx = fast || partial;
				if (was_rec && !was_to) begin
					if (full)
						w_out = ss;
					else if (partial)
						w_out = w_in + (cack - old_start) + 1;
					else if (is_dup)
						w_out = w_in + 1;
					else
						w_out = w_in;
				end else if (is_new) begin
					if (w_in < ss || 32'(c.incr) == w_in)
						w_out = w_in - old_dup + 1;
					else
						w_out = w_in - old_dup;
				end else if (is_dup) begin
					w_out = w_in + 1;
				end else begin
					w_out = w_in;
				end
				c.wsize = (w_out > lim) ? lim[8:0] : w_out[8:0];
				c.in_rec = (was_rec && cack <= rec) || fast;
				r.restart = !c.in_rec;
				if (c.in_rec && !was_to)
					c.incr = '0;
				else if (is_new && w_in >= ss)
					c.incr = (32'(c.incr) == w_in) ? '0 : c.incr + 9'd1;
				c.in_to = was_to && !full;
				if (is_new)
					c.prev_ack = old_start;
				if (fast) begin
					c.recov = c.nxt - 32'd1;
					c.ssthr = w_in[9:1];
				end
			end
			CMD_TIMEOUT: begin
				// window drops to exactly one, no limit clamp
				rtx = 1'b1;
				c.wsize = 9'd1;
				c.dups = '0;
				if (c.ssthr > 9'd2)
					c.ssthr = 9'd2;
				c.incr = '0;
				c.in_to = 1'b1;
				c.recov = c.nxt - 32'd1;
			end
			CMD_SEND: begin
				wend = c.wstart + 32'(c.wsize);
				if (c.nxt < wend) begin
					r.send_v = 1'b1;
					r.send_s = c.nxt;
					c.nxt = c.nxt + 32'd1;
				end
			end
			default: ;
		endcase
		wend = c.wstart + 32'(c.wsize);
		r.rtx_v = rtx;
		r.rtx_s = rtx ? c.wstart : '0;
		r.win = c.wsize;
		r.recov = c.in_rec;
		r.full = c.nxt >= wend;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			failures++;
		end
	endfunction

	// Queue one word for the driver, advancing the planning copy of its flow.
	task automatic plan_word(input logic [CMD_W-1:0] op, input logic [FLOW_W-1:0] fl,
			input logic [SEQ_W-1:0] cack);
		cmd_word_t    w;
		flow_ctx_t    c;
		reno_result_t ignored;
		w.op = op;
		w.fl = fl;
		w.cack = cack;
		c = ctx_plan[fl];
		ignored = newreno_step(c, tuning, op, fl, cack);
		ctx_plan[fl] = c;
		cmd_backlog.push_back(w);
		words_queued++;
	endtask

	// Mostly well-formed traffic on a few live flows: sends, acks inside the
	// outstanding range, duplicate acks; less often stale and wild acks, timeouts, junk codes.
	task automatic plan_burst(input int count, input int base);
		logic [FLOW_W-1:0] active [6];
		logic [FLOW_W-1:0] fl;
		logic [SEQ_W-1:0]  span;
		logic [SEQ_W-1:0]  cack;
		flow_ctx_t         c;
		int                pick;
		int                i;
		int                j;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0)
				for (j = 0; j < 6; j++)
					active[j] = ($urandom_range(0, 3) != 0) ?
						FLOW_W'(base + $urandom_range(0, 127)) : FLOW_W'($urandom_range(0, 1023));
			fl = active[$urandom_range(0, 5)];
			c = ctx_plan[fl];
			span = c.nxt - c.wstart;
			pick = $urandom_range(0, 99);
			cack = $urandom;
			if (pick < 38)
				plan_word(CMD_SEND, fl, cack);
			else if (pick < 63 && span != 0 && span <= 4096)
				plan_word(CMD_ACK, fl, c.wstart + $urandom_range(1, span));
			else if (pick < 85)
				plan_word(CMD_ACK, fl, c.wstart);
			else if (pick < 90)
				plan_word(CMD_ACK, fl, c.wstart - $urandom_range(1, 50));
			else if (pick < 94)
				plan_word(CMD_ACK, fl, cack);
			else if (pick < 98)
				plan_word(CMD_TIMEOUT, fl, cack);
			else
				plan_word(CMD_OTHER, fl, cack);
		end
	endtask

	// APB write with setup and access cycles, then read back the same register.
	task automatic reg_write(input reg_e_t idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] mask;
		mask = (idx == REG_DUP_THR) ? 32'h0000_000F : 32'h0000_01FF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			$error("%s readback: expected 0x%0h, got 0x%0h", idx.name(), value & mask,
				prdata & mask);
			failures++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_INIT_WINDOW: tuning.init_win = value[WIN_W-1:0];
			REG_INIT_SS:     tuning.init_ss = value[WIN_W-1:0];
			REG_DUP_THR:     tuning.dup_thr = value[THR_W-1:0];
			REG_WIN_LIMIT:   tuning.win_lim = value[WIN_W-1:0];
			default: ;
		endcase
	endtask

	// Hold until every planned word has come back as a result.
	task automatic settle();
		do
			@(negedge clk);
		while (results_seen != words_queued);
	endtask

	// Driver: present one word at a time; after each acceptance drop valid for a
	// drawn gap, except in calm stretches where words go back to back.
	always @(negedge clk) begin
		if (word_taken) begin
			word_taken = 1'b0;
			offering = 1'b0;
			send_gap = send_calm ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 99) == 0)
				send_calm = !send_calm;
		end
		if (!offering) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (cmd_backlog.size() != 0) begin
				next_word = cmd_backlog.pop_front();
				command <= next_word.op;
				flow <= next_word.fl;
				cum_ack <= next_word.cack;
				offering = 1'b1;
			end
		end
		in_valid <= offering;
	end

	// Receiver: stall for a drawn number of cycles before each result, and hold
	// off entirely while a long hold is in force.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (result_taken) begin
			result_taken = 1'b0;
			recv_gap = recv_calm ? 0 : $urandom_range(0, 10);
			if ($urandom_range(0, 99) == 0)
				recv_calm = !recv_calm;
		end
		if (hold_left > 0) begin
			hold_left--;
			busy = 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			busy = 1'b1;
		end else begin
			busy = 1'b0;
		end
		out_stall <= busy;
	end

	// Monitor: check results first (a result never belongs to the word taken at
	// the same edge), then predict the result of the word just accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				result_taken = 1'b1;
				if (due_results.size() == 0) begin
					$error("result for flow 0x%0h with no word outstanding", flow_out);
					failures++;
				end else begin
					want = due_results.pop_front();
					check_field("flow_out", 32'(want.flow_id), 32'(flow_out));
					check_field("send_valid", 32'(want.send_v), 32'(send_valid));
					check_field("send_seq", want.send_s, send_seq);
					check_field("window", 32'(want.win), 32'(window));
					check_field("retransmit_valid", 32'(want.rtx_v), 32'(retransmit_valid));
					check_field("retransmit_seq", want.rtx_s, retransmit_seq);
					check_field("restart_timer", 32'(want.restart), 32'(restart_timer));
					check_field("recovering", 32'(want.recov), 32'(recovering));
					check_field("window_full", 32'(want.full), 32'(window_full));
				end
				if (retransmit_valid)
					n_rtx++;
				if (send_valid)
					n_issued++;
				if (recovering)
					n_recov++;
			end
			if (in_valid && !in_stall) begin
				word_taken = 1'b1;
				ctx_now = ctx_model[flow];
				due_results.push_back(newreno_step(ctx_now, tuning, command, flow, cum_ack));
				ctx_model[flow] = ctx_now;
				case (command)
					CMD_ACK:     n_ack++;
					CMD_TIMEOUT: n_timeout++;
					CMD_SEND:    n_send++;
					default:     n_other++;
				endcase
			end
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("** newreno_flow_window_engine_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [FLOW_W-1:0] storm_flow;
		int                ph;
		int                fi;
		for (fi = 0; fi < NUM_FLOWS; fi++) begin
			ctx_plan[fi] = '{default: '0};
			ctx_model[fi] = '{default: '0};
		end
		tuning.init_win = RST_INIT_WINDOW;
		tuning.init_ss = RST_INIT_SS;
		tuning.dup_thr = RST_DUP_THR;
		tuning.win_lim = RST_WIN_LIMIT;

		// hold reset, then release it on a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under reset settings; the block stalls them until its
		// context sweep is over
		plan_word(CMD_SEND, 10'd0, 32'h0);
		plan_word(CMD_SEND, 10'd0, 32'hFFFF_FFFF);
		plan_word(CMD_SEND, 10'd0, 32'h0);
		plan_word(CMD_SEND, 10'd0, 32'h0);
		plan_word(CMD_ACK, 10'd0, 32'd1);
		// three duplicates: fast retransmit and entry into recovery
		plan_word(CMD_ACK, 10'd0, 32'd1);
		plan_word(CMD_ACK, 10'd0, 32'd1);
		plan_word(CMD_ACK, 10'd0, 32'd1);
		// partial ack, then the ack that ends recovery
		plan_word(CMD_ACK, 10'd0, 32'd2);
		plan_word(CMD_ACK, 10'd0, 32'd4);
		plan_word(CMD_TIMEOUT, 10'd0, 32'h0);
		plan_word(CMD_SEND, 10'd0, 32'h0);
		plan_word(CMD_ACK, 10'd0, 32'd5);
		// unknown code on an untouched flow, then a window end that wraps past zero
		plan_word(CMD_OTHER, 10'd1023, 32'hFFFF_FFFF);
		plan_word(CMD_ACK, 10'd1023, 32'hFFFF_FFFF);
		plan_word(CMD_SEND, 10'd1023, 32'h0);
		plan_word(CMD_SEND, 10'd1023, 32'h0);
		plan_word(CMD_ACK, 10'd1023, 32'h0);
		plan_word(CMD_TIMEOUT, 10'd1023, 32'h0);
		plan_word(CMD_ACK, 10'd1023, 32'h0);
		plan_word(CMD_ACK, 10'h155, 32'h5555_5555);
		plan_word(CMD_ACK, 10'h2AA, 32'hAAAA_AAAA);
		plan_word(CMD_TIMEOUT, 10'd1, 32'h0);
		plan_word(CMD_ACK, 10'd1, 32'd0);
		// sender pause: drain every result before the random traffic starts
		settle();
		@(posedge clk);
		plan_burst(280, 0);

		for (ph = 1; ph <= 5; ph++) begin
			settle();
			@(posedge clk);
			case (ph)
				1: begin
					reg_write(REG_INIT_WINDOW, 32'd1);
					reg_write(REG_INIT_SS, 32'd1);
					reg_write(REG_DUP_THR, 32'd1);
					reg_write(REG_WIN_LIMIT, 32'd1);
				end
				2: begin
					reg_write(REG_INIT_WINDOW, 32'd256);
					reg_write(REG_INIT_SS, 32'd256);
					reg_write(REG_DUP_THR, 32'd15);
					reg_write(REG_WIN_LIMIT, 32'd256);
				end
				3: begin
					// zero threshold: a fresh ack can trigger fast retransmit
					reg_write(REG_INIT_WINDOW, 32'd4);
					reg_write(REG_INIT_SS, 32'd8);
					reg_write(REG_DUP_THR, 32'd0);
					reg_write(REG_WIN_LIMIT, 32'd16);
				end
				4: begin
					reg_write(REG_INIT_WINDOW, $urandom_range(1, 256));
					reg_write(REG_INIT_SS, $urandom_range(1, 256));
					reg_write(REG_DUP_THR, $urandom_range(1, 15));
					reg_write(REG_WIN_LIMIT, $urandom_range(1, 256));
				end
				default: begin
					reg_write(REG_INIT_WINDOW, 32'(RST_INIT_WINDOW));
					reg_write(REG_INIT_SS, 32'(RST_INIT_SS));
					reg_write(REG_DUP_THR, 32'(RST_DUP_THR));
					reg_write(REG_WIN_LIMIT, 32'(RST_WIN_LIMIT));
				end
			endcase
			@(posedge clk);
			// long receiver hold: the pipeline fills and the input stalls
			if (ph == 3)
				hold_req = LONG_HOLD;
			plan_burst(280, ph * 128);
			// duplicate storm: run the dup count up to saturation
			if (ph == 2) begin
				storm_flow = 10'd777;
				repeat (6) plan_word(CMD_SEND, storm_flow, $urandom);
				repeat (270) plan_word(CMD_ACK, storm_flow, ctx_plan[storm_flow].wstart);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d expected results never arrived", due_results.size());
			failures++;
		end
		$display("Covered %0d words: %0d acks, %0d timeouts, %0d sends, %0d unknown codes,",
			words_queued, n_ack, n_timeout, n_send, n_other);
		$display("  over six register settings; %0d retransmit marks, %0d sequences issued.",
			n_rtx, n_issued);
		if (failures == 0)
			$display("** newreno_flow_window_engine_core: PASSED **");
		else
			$display("** newreno_flow_window_engine_core: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/nfwe_pkg.sv
src/newreno_flow_window_engine_core.sv
test/tb_newreno_flow_window_engine_core.sv
